// ----- rtl/core/uvs_pkg.sv -----
// Shared types, constants and the arctangent table of the UV-sphere mesh generator.
package uvs_pkg;

  localparam int MAX_SECTORS_DEF = 256;
  localparam int MAX_STACKS_DEF  = 256;
  localparam int ANGLE_BITS_DEF  = 16;

  localparam int RAD_W      = 15;
  localparam int CNT_W      = 9;
  localparam int IDX_W      = 17;
  localparam int COORD_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECTORS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STACKS  = 2'd2;

  localparam logic [RAD_W-1:0] RADIUS_RST  = 15'd256;
  localparam logic [CNT_W-1:0] SECTORS_RST = 9'd36;
  localparam logic [CNT_W-1:0] STACKS_RST  = 9'd18;

  localparam int MIN_SECTORS = 3;
  localparam int MIN_STACKS  = 2;

  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W       = 5;
  localparam int CORDIC_GAIN  = 652032874;

  // One unit of work handed from the sequencer to the datapath
  typedef struct packed {
    logic             is_tri;
    logic             last;
    logic [IDX_W-1:0] ca;
    logic [IDX_W-1:0] cb;
    logic [IDX_W-1:0] cc;
    logic [CNT_W-1:0] stack_pos;
    logic [CNT_W-1:0] sector_pos;
    logic [CNT_W-1:0] sectors;
    logic [CNT_W-1:0] stacks;
    logic [RAD_W-1:0] radius;
  } job_t;

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [29:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10680862;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/uvs_queue.sv -----
// Two-entry job queue between the sequencer and the vertex datapath.
module uvs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  uvs_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output uvs_pkg::job_t head
);

  uvs_pkg::job_t mem_r [2];
  logic          wp_r;
  logic          rp_r;
  logic [1:0]    cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- rtl/core/uvs_front.sv -----
// Sequencer: configuration registers, mesh walk and triangle corner indices.
module uvs_front #(
  parameter int MAX_SECTORS = uvs_pkg::MAX_SECTORS_DEF,
  parameter int MAX_STACKS  = uvs_pkg::MAX_STACKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [uvs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [uvs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_restart,
  input  logic                             q_full,
  output logic                             q_push,
  output uvs_pkg::job_t                    q_job
);

  localparam int CW = uvs_pkg::CNT_W;

  function automatic logic [CW-1:0] clamp_cnt(input logic [CW-1:0] c, input int lo,
                                              input int hi);
    logic [CW-1:0] r;
    if (int'(c) < lo) begin
      r = CW'(lo);
    end else if (int'(c) > hi) begin
      r = CW'(hi);
    end else begin
      r = c;
    end
    return r;
  endfunction

  logic [uvs_pkg::RAD_W-1:0] radius_r, lat_radius_r;
  logic [CW-1:0]             sectors_r, stacks_r, lat_sec_r, lat_stk_r;
  logic                      phase_r, lower_r, fin_r;
  logic [CW-1:0]             stack_r, sector_r;

  logic          accept;
  logic [CW:0]   sec_inc, stk_inc, sec_p1;
  logic [18:0]   prod;
  logic [19:0]   k1, k2;
  logic          lower, adv;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;
  assign q_push    = accept && !in_restart && !fin_r;

  assign sec_inc = {1'b0, sector_r} + 10'd1;
  assign stk_inc = {1'b0, stack_r} + 10'd1;
  assign sec_p1  = {1'b0, lat_sec_r} + 10'd1;
  assign prod    = {10'b0, stack_r} * {9'b0, sec_p1};
  assign k1      = {1'b0, prod} + {11'b0, sector_r};
  assign k2      = k1 + {10'b0, sec_p1};
  assign lower   = lower_r || (stack_r == '0);
  assign adv     = lower || ({1'b0, stack_r} == {1'b0, lat_stk_r} - 10'd1);

  always_comb begin
    q_job            = '0;
    q_job.stack_pos  = stack_r;
    q_job.sector_pos = sector_r;
    q_job.sectors    = lat_sec_r;
    q_job.stacks     = lat_stk_r;
    q_job.radius     = lat_radius_r;
    if (phase_r) begin
      q_job.is_tri = 1'b1;
      if (lower) begin
        q_job.ca = 17'(k1 + 20'd1);
        q_job.cb = k2[16:0];
        q_job.cc = 17'(k2 + 20'd1);
      end else begin
        q_job.ca = k1[16:0];
        q_job.cb = k2[16:0];
        q_job.cc = 17'(k1 + 20'd1);
      end
      q_job.last = adv && (sec_inc >= {1'b0, lat_sec_r}) &&
                   (stk_inc >= {1'b0, lat_stk_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r     <= uvs_pkg::RADIUS_RST;
      sectors_r    <= uvs_pkg::SECTORS_RST;
      stacks_r     <= uvs_pkg::STACKS_RST;
      lat_radius_r <= uvs_pkg::RADIUS_RST;
      lat_sec_r    <= clamp_cnt(uvs_pkg::SECTORS_RST, uvs_pkg::MIN_SECTORS, MAX_SECTORS);
      lat_stk_r    <= clamp_cnt(uvs_pkg::STACKS_RST, uvs_pkg::MIN_STACKS, MAX_STACKS);
      phase_r      <= 1'b0;
      lower_r      <= 1'b0;
      fin_r        <= 1'b1;
      stack_r      <= '0;
      sector_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          uvs_pkg::REG_RADIUS:  radius_r  <= cfg_data;
          uvs_pkg::REG_SECTORS: sectors_r <= cfg_data[CW-1:0];
          uvs_pkg::REG_STACKS:  stacks_r  <= cfg_data[CW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (in_restart) begin
          lat_radius_r <= radius_r;
          lat_sec_r    <= clamp_cnt(sectors_r, uvs_pkg::MIN_SECTORS, MAX_SECTORS);
          lat_stk_r    <= clamp_cnt(stacks_r, uvs_pkg::MIN_STACKS, MAX_STACKS);
          phase_r      <= 1'b0;
          lower_r      <= 1'b0;
          fin_r        <= 1'b0;
          stack_r      <= '0;
          sector_r     <= '0;
        end else if (!fin_r) begin
          if (!phase_r) begin
            // vertex walk includes the seam column and both poles
            if (sec_inc > {1'b0, lat_sec_r}) begin
              sector_r <= '0;
              if (stk_inc > {1'b0, lat_stk_r}) begin
                stack_r <= '0;
                phase_r <= 1'b1;
                lower_r <= 1'b0;
              end else begin
                stack_r <= stk_inc[CW-1:0];
              end
            end else begin
              sector_r <= sec_inc[CW-1:0];
            end
          end else begin
            lower_r <= !adv;
            if (adv) begin
              if (sec_inc >= {1'b0, lat_sec_r}) begin
                sector_r <= '0;
                stack_r  <= stk_inc[CW-1:0];
                if (stk_inc >= {1'b0, lat_stk_r}) begin
                  fin_r <= 1'b1;
                end
              end else begin
                sector_r <= sec_inc[CW-1:0];
              end
            end
          end
        end
      end
    end
  end

endmodule

// ----- rtl/core/uvs_back.sv -----
// Vertex datapath: angle division, CORDIC sine/cosine, products, rounding, scaling and output register.
module uvs_back #(
  parameter int ANGLE_BITS = uvs_pkg::ANGLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  uvs_pkg::job_t                   q_job,
  output logic                            q_pop,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic                            out_is_triangle,
  output logic signed [uvs_pkg::COORD_W-1:0] out_pos_x,
  output logic signed [uvs_pkg::COORD_W-1:0] out_pos_y,
  output logic signed [uvs_pkg::COORD_W-1:0] out_pos_z,
  output logic signed [uvs_pkg::COORD_W-1:0] out_norm_x,
  output logic signed [uvs_pkg::COORD_W-1:0] out_norm_y,
  output logic signed [uvs_pkg::COORD_W-1:0] out_norm_z,
  output logic [uvs_pkg::IDX_W-1:0]       out_corner_a,
  output logic [uvs_pkg::IDX_W-1:0]       out_corner_b,
  output logic [uvs_pkg::IDX_W-1:0]       out_corner_c,
  output logic                            out_last_of_mesh
);

  localparam int A    = ANGLE_BITS;
  localparam int NW   = uvs_pkg::CNT_W;
  localparam int XW   = 34;
  localparam int ZW   = 33;
  localparam int PW   = 2 * XW;
  localparam int RW   = uvs_pkg::RAD_W + 1 + XW;
  localparam int OW   = uvs_pkg::COORD_W;
  localparam int MAXC = (A > uvs_pkg::CORDIC_STEPS) ? A : uvs_pkg::CORDIC_STEPS;
  localparam int CW   = $clog2(MAXC + 1);

  localparam logic [A:0]            QUARTER = (A+1)'(1) << (A - 2);
  localparam logic signed [PW-1:0]  HALF_P  = PW'(1) << 29;
  localparam logic signed [RW-1:0]  HALF_R  = RW'(1) << 29;
  localparam logic signed [XW-1:0]  HALF_N  = XW'(1) << 15;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_DIV   = 8'b00000010,
    S_ANG   = 8'b00000100,
    S_ROT   = 8'b00001000,
    S_PROD  = 8'b00010000,
    S_RND   = 8'b00100000,
    S_SCALE = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  // Fold to [-1/4, 1/4) turn; msb of the result flags the half-turn flip
  function automatic logic [ZW:0] reduce(input logic [A-1:0] ang);
    logic [31:0] a;
    logic [31:0] t;
    logic        fl;
    a  = {ang, {(32 - A){1'b0}}};
    t  = a + 32'h4000_0000;
    fl = t[31];
    if (fl) begin
      a = a ^ 32'h8000_0000;
    end
    return {fl, a[31], a};
  endfunction

  function automatic logic signed [OW-1:0] clamp_norm(input logic signed [XW-1:0] c);
    logic signed [XW-1:0] r;
    logic signed [OW-1:0] o;
    r = (c + HALF_N) >>> 16;
    if (r > 16384) begin
      o = 16'sd16384;
    end else if (r < -16384) begin
      o = -16'sd16384;
    end else begin
      o = r[OW-1:0];
    end
    return o;
  endfunction

  function automatic logic signed [OW-1:0] clamp_pos(input logic signed [RW-1:0] p);
    logic signed [RW-1:0] r;
    logic signed [OW-1:0] o;
    r = (p + HALF_R) >>> 30;
    if (r > 32767) begin
      o = 16'sd32767;
    end else if (r < -32767) begin
      o = -16'sd32767;
    end else begin
      o = r[OW-1:0];
    end
    return o;
  endfunction

  state_t state_r, state_nxt;
  uvs_pkg::job_t job_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] rs_r, rc_r;
  logic [A:0]    qs_r, qc_r;
  logic signed [XW-1:0] xs_r, ys_r, xc_r, yc_r;
  logic signed [ZW-1:0] zs_r, zc_r;
  logic                 fs_r, fc_r;
  logic signed [PW-1:0] p0_r, p1_r;
  logic signed [XW-1:0] sz_r;
  logic signed [XW-1:0] c0_r, c1_r, c2_r;
  logic signed [RW-1:0] r0_r, r1_r, r2_r;
  logic signed [OW-1:0] n0_r, n1_r, n2_r;
  logic                 out_valid_r;

  // combinational step values
  logic [NW:0]          rs2, rc2;
  logic                 gs, gc;
  logic [A:0]           st_full;
  logic [ZW:0]          red_s, red_c;
  logic signed [ZW-1:0] at;
  logic signed [XW-1:0] xs_n, ys_n, xc_n, yc_n;
  logic signed [ZW-1:0] zs_n, zc_n;
  logic signed [XW-1:0] cst, sst, cse, sse;
  logic signed [PW-1:0] p0_sh, p1_sh;
  logic signed [OW:0]   rad;
  logic                 out_free;
  logic                 init_gs, init_gc;

  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = (state_r == S_IDLE) && q_valid;

  assign rs2 = {rs_r, 1'b0};
  assign rc2 = {rc_r, 1'b0};
  assign gs  = rs2 >= {1'b0, job_r.stacks};
  assign gc  = rc2 >= {1'b0, job_r.sectors};

  assign init_gs = q_job.stack_pos >= q_job.stacks;
  assign init_gc = q_job.sector_pos >= q_job.sectors;

  // stack quotient was taken over a full turn; halve it for the half-turn span
  assign st_full = QUARTER - {1'b0, qs_r[A:1]};
  assign red_s   = reduce(st_full[A-1:0]);
  assign red_c   = reduce(qc_r[A-1:0]);

  assign at = $signed({3'b000, uvs_pkg::atan_turn(uvs_pkg::STEP_W'(cnt_r))});

  always_comb begin
    if (!zs_r[ZW-1]) begin
      xs_n = xs_r - (ys_r >>> cnt_r);
      ys_n = ys_r + (xs_r >>> cnt_r);
      zs_n = zs_r - at;
    end else begin
      xs_n = xs_r + (ys_r >>> cnt_r);
      ys_n = ys_r - (xs_r >>> cnt_r);
      zs_n = zs_r + at;
    end
    if (!zc_r[ZW-1]) begin
      xc_n = xc_r - (yc_r >>> cnt_r);
      yc_n = yc_r + (xc_r >>> cnt_r);
      zc_n = zc_r - at;
    end else begin
      xc_n = xc_r + (yc_r >>> cnt_r);
      yc_n = yc_r - (xc_r >>> cnt_r);
      zc_n = zc_r + at;
    end
  end

  assign cst   = fs_r ? -xs_r : xs_r;
  assign sst   = fs_r ? -ys_r : ys_r;
  assign cse   = fc_r ? -xc_r : xc_r;
  assign sse   = fc_r ? -yc_r : yc_r;
  assign p0_sh = (p0_r + HALF_P) >>> 30;
  assign p1_sh = (p1_r + HALF_P) >>> 30;
  assign rad   = $signed({1'b0, job_r.radius});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          state_nxt = q_job.is_tri ? S_OUT : S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_r == CW'(A - 1)) begin
          state_nxt = S_ANG;
        end
      end
      S_ANG:   state_nxt = S_ROT;
      S_ROT: begin
        if (cnt_r == CW'(uvs_pkg::CORDIC_STEPS - 1)) begin
          state_nxt = S_PROD;
        end
      end
      S_PROD:  state_nxt = S_RND;
      S_RND:   state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        cnt_r <= '0;
        if (q_valid) begin
          job_r <= q_job;
          qs_r  <= (A+1)'(init_gs);
          qc_r  <= (A+1)'(init_gc);
          rs_r  <= init_gs ? '0 : q_job.stack_pos;
          rc_r  <= init_gc ? '0 : q_job.sector_pos;
        end
      end
      S_DIV: begin
        qs_r  <= {qs_r[A-1:0], gs};
        qc_r  <= {qc_r[A-1:0], gc};
        rs_r  <= NW'(rs2 - (gs ? {1'b0, job_r.stacks} : '0));
        rc_r  <= NW'(rc2 - (gc ? {1'b0, job_r.sectors} : '0));
        cnt_r <= (cnt_r == CW'(A - 1)) ? '0 : cnt_r + CW'(1);
      end
      S_ANG: begin
        fs_r <= red_s[ZW];
        fc_r <= red_c[ZW];
        zs_r <= $signed(red_s[ZW-1:0]);
        zc_r <= $signed(red_c[ZW-1:0]);
        xs_r <= XW'(uvs_pkg::CORDIC_GAIN);
        xc_r <= XW'(uvs_pkg::CORDIC_GAIN);
        ys_r <= '0;
        yc_r <= '0;
      end
      S_ROT: begin
        xs_r  <= xs_n;
        ys_r  <= ys_n;
        zs_r  <= zs_n;
        xc_r  <= xc_n;
        yc_r  <= yc_n;
        zc_r  <= zc_n;
        cnt_r <= cnt_r + CW'(1);
      end
      S_PROD: begin
        p0_r <= cst * cse;
        p1_r <= cst * sse;
        sz_r <= sst;
      end
      S_RND: begin
        c0_r <= p0_sh[XW-1:0];
        c1_r <= p1_sh[XW-1:0];
        c2_r <= sz_r;
      end
      S_SCALE: begin
        r0_r <= rad * c0_r;
        r1_r <= rad * c1_r;
        r2_r <= rad * c2_r;
        n0_r <= clamp_norm(c0_r);
        n1_r <= clamp_norm(c1_r);
        n2_r <= clamp_norm(c2_r);
      end
      S_OUT: begin
        if (out_free) begin
          out_is_triangle  <= job_r.is_tri;
          out_last_of_mesh <= job_r.last;
          if (job_r.is_tri) begin
            out_pos_x    <= '0;
            out_pos_y    <= '0;
            out_pos_z    <= '0;
            out_norm_x   <= '0;
            out_norm_y   <= '0;
            out_norm_z   <= '0;
            out_corner_a <= job_r.ca;
            out_corner_b <= job_r.cb;
            out_corner_c <= job_r.cc;
          end else begin
            out_pos_x    <= clamp_pos(r0_r);
            out_pos_y    <= clamp_pos(r1_r);
            out_pos_z    <= clamp_pos(r2_r);
            out_norm_x   <= n0_r;
            out_norm_y   <= n1_r;
            out_norm_z   <= n2_r;
            out_corner_a <= '0;
            out_corner_b <= '0;
            out_corner_c <= '0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/uv_sphere_mesh_generator_unit.sv -----
// Top level of the UV-sphere mesh generator.
//
//  channel  direction  handshake              payload
//  cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//  in       in         in_valid / in_stall    in_restart
//  out      out        out_valid / out_stall  out_is_triangle .. out_last_of_mesh
//
// In the datapath a vertex passes angle division (one quotient bit a cycle), 20 CORDIC
// rotations, then product, round and scale stages; a triangle goes straight to the
// output register. The sequencer runs ahead through a two-entry job queue.
// Synchronous active-low reset; the mesh is idle until the first restart item.
// in_stall rises only when the job queue is full; the output register holds under out_stall.
module uv_sphere_mesh_generator_unit #(
  parameter int MAX_SECTORS = uvs_pkg::MAX_SECTORS_DEF,
  parameter int MAX_STACKS  = uvs_pkg::MAX_STACKS_DEF,
  parameter int ANGLE_BITS  = uvs_pkg::ANGLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [uvs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [uvs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_restart,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_is_triangle,
  output logic signed [uvs_pkg::COORD_W-1:0] out_pos_x,
  output logic signed [uvs_pkg::COORD_W-1:0] out_pos_y,
  output logic signed [uvs_pkg::COORD_W-1:0] out_pos_z,
  output logic signed [uvs_pkg::COORD_W-1:0] out_norm_x,
  output logic signed [uvs_pkg::COORD_W-1:0] out_norm_y,
  output logic signed [uvs_pkg::COORD_W-1:0] out_norm_z,
  output logic [uvs_pkg::IDX_W-1:0]          out_corner_a,
  output logic [uvs_pkg::IDX_W-1:0]          out_corner_b,
  output logic [uvs_pkg::IDX_W-1:0]          out_corner_c,
  output logic                               out_last_of_mesh
);

  logic          q_push, q_full, q_pop, q_valid;
  uvs_pkg::job_t push_job, head_job;

  uvs_front #(
    .MAX_SECTORS (MAX_SECTORS),
    .MAX_STACKS  (MAX_STACKS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_restart (in_restart),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (push_job)
  );

  uvs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head_job)
  );

  uvs_back #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_job            (head_job),
    .q_pop            (q_pop),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_is_triangle  (out_is_triangle),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_pos_z        (out_pos_z),
    .out_norm_x       (out_norm_x),
    .out_norm_y       (out_norm_y),
    .out_norm_z       (out_norm_z),
    .out_corner_a     (out_corner_a),
    .out_corner_b     (out_corner_b),
    .out_corner_c     (out_corner_c),
    .out_last_of_mesh (out_last_of_mesh)
  );

endmodule
